// ----- rtl/core/random_page_replacement_table_top_assert.svh -----
// ----------------------------------------------------------------------------
// Random page replacement table - assertion macros
// Shared concurrent assertion macros, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PAGE_REPLACEMENT_TABLE_TOP_ASSERT_SVH
`define RANDOM_PAGE_REPLACEMENT_TABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RPT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RPT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RPT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define RPT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ----- rtl/core/rpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Random page replacement table - package
// Sizes, register codes and the types shared by the table's modules.
// ----------------------------------------------------------------------------
package rpt_pkg;

  // table geometry
  localparam int PAGES    = 256;
  localparam int FRAMES   = 64;
  localparam int PAGE_W   = $clog2(PAGES);
  localparam int FRAME_W  = $clog2(FRAMES);
  localparam int RANK_W   = 6;
  localparam int NPAGES_W = 9;
  localparam int RCOUNT_W = 7;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [NPAGES_W-1:0] NPAGES_RST = NPAGES_W'(256);
  localparam logic [RCOUNT_W-1:0] RCOUNT_RST = RCOUNT_W'(64);

  // register indexes
  localparam logic REG_NUM_PAGES      = 1'b0;
  localparam logic REG_RESIDENT_COUNT = 1'b1;

  // item operations
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_INIT   = 1'b1;

  // one page table entry
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // sequencer to chain control
  typedef struct packed {
    logic   shift;
    entry_t wb;
  } chain_ctl_t;

  // one result item
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               load_needed;
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_valid;
    logic               bad_page;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_LOOK,
    S_DECIDE,
    S_MOVE,
    S_DONE
  } seq_state_t;

endpackage

// ----- rtl/core/rpt_cell.sv -----
// ----------------------------------------------------------------------------
// Random page replacement table - cell
// Holds one page table entry and takes its neighbour's entry on a shift.
// ----------------------------------------------------------------------------
module rpt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  rpt_pkg::entry_t d,
  output rpt_pkg::entry_t q
);
  import rpt_pkg::*;

  logic               valid_r;
  logic [FRAME_W-1:0] frame_r;

  // valid bit, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d.valid;
    end
  end

  // frame number, only meaningful while valid
  always_ff @(posedge clk) begin
    if (shift_en) begin
      frame_r <= d.frame;
    end
  end

  assign q.valid = valid_r;
  assign q.frame = frame_r;

endmodule

// ----- rtl/core/rpt_chain.sv -----
// ----------------------------------------------------------------------------
// Random page replacement table - cell chain
// Ring of cells, one per page; the head entry leaves at cell 0 and the
// written-back entry enters at the far end, so a full pass restores order.
// ----------------------------------------------------------------------------
module rpt_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  rpt_pkg::chain_ctl_t ctl,
  output rpt_pkg::entry_t     head
);
  import rpt_pkg::*;

  entry_t cell_q [PAGES];

  // row of cells, each fed by its upper neighbour, the last one by the written-back entry
  for (genvar k = 0; k < PAGES; k++) begin : g_cell
    entry_t cell_d;
    if (k == PAGES - 1) begin : g_tail
      assign cell_d = ctl.wb;
    end else begin : g_body
      assign cell_d = cell_q[k+1];
    end
    rpt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ctl.shift),
      .d        (cell_d),
      .q        (cell_q[k])
    );
  end

  assign head = cell_q[0];

endmodule

// ----- rtl/core/rpt_seq.sv -----
// ----------------------------------------------------------------------------
// Random page replacement table - sequencer
// Takes items, walks the cell ring for lookup, victim search, eviction and
// init, and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "random_page_replacement_table_top_assert.svh"

module rpt_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [rpt_pkg::PAGE_W-1:0]    in_page,
  input  logic [rpt_pkg::RANK_W-1:0]    in_victim_rank,
  input  logic [rpt_pkg::NPAGES_W-1:0]  num_pages,
  input  logic [rpt_pkg::RCOUNT_W-1:0]  resident_count,
  input  rpt_pkg::entry_t               head,
  output rpt_pkg::chain_ctl_t           ctl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rpt_pkg::result_t              res
);
  import rpt_pkg::*;

  seq_state_t           state_r, state_nxt;
  logic [PAGE_W-1:0]    idx_r, idx_nxt;
  logic [PAGE_W-1:0]    page_r, page_nxt;
  logic [RANK_W-1:0]    target_r, target_nxt;
  logic [RANK_W-1:0]    seen_r, seen_nxt;
  logic [NPAGES_W-1:0]  init_cnt_r, init_cnt_nxt;
  logic                 hit_r, hit_nxt;
  logic [FRAME_W-1:0]   hfrm_r, hfrm_nxt;
  logic                 found_r, found_nxt;
  logic                 done_r, done_nxt;
  logic [PAGE_W-1:0]    victim_r, victim_nxt;
  logic [FRAME_W-1:0]   vframe_r, vframe_nxt;
  result_t              res_r, res_nxt;
  result_t              out_res_r, out_res_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 accept;
  logic                 last;
  logic                 bad;
  logic [RCOUNT_W-1:0]  rc_m2;
  logic [RANK_W-1:0]    clamp;
  logic [NPAGES_W-1:0]  rc_ext;
  logic [NPAGES_W-1:0]  min_np_rc;
  logic [NPAGES_W-1:0]  init_cnt;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last     = (idx_r == PAGE_W'(PAGES - 1));

  // rank clamp to resident_count - 2
  assign rc_m2 = resident_count - RCOUNT_W'(2);
  always_comb begin
    if (resident_count < RCOUNT_W'(2)) begin
      clamp = '0;
    end else if (RCOUNT_W'(in_victim_rank) <= rc_m2) begin
      clamp = in_victim_rank;
    end else begin
      clamp = rc_m2[RANK_W-1:0];
    end
  end

  // pages made resident by init
  assign rc_ext    = NPAGES_W'(resident_count);
  assign min_np_rc = (num_pages < rc_ext) ? num_pages : rc_ext;
  assign init_cnt  = (min_np_rc < NPAGES_W'(FRAMES)) ? min_np_rc : NPAGES_W'(FRAMES);

  // page beyond the image
  assign bad = (NPAGES_W'(in_page) >= num_pages);

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    page_nxt      = page_r;
    target_nxt    = target_r;
    seen_nxt      = seen_r;
    init_cnt_nxt  = init_cnt_r;
    hit_nxt       = hit_r;
    hfrm_nxt      = hfrm_r;
    found_nxt     = found_r;
    done_nxt      = done_r;
    victim_nxt    = victim_r;
    vframe_nxt    = vframe_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    ctl.shift     = 1'b0;
    ctl.wb        = head;

    // output register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          page_nxt     = in_page;
          target_nxt   = clamp;
          init_cnt_nxt = init_cnt;
          seen_nxt     = '0;
          hit_nxt      = 1'b0;
          found_nxt    = 1'b0;
          done_nxt     = 1'b0;
          res_nxt      = '0;
          if (in_op == OP_INIT) begin
            state_nxt = S_INIT;
          end else if (bad) begin
            res_nxt.bad_page = 1'b1;
            state_nxt        = S_DONE;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end

      // rewrite every entry in one pass
      S_INIT: begin
        ctl.shift    = 1'b1;
        ctl.wb.valid = (NPAGES_W'(idx_r) < init_cnt_r);
        ctl.wb.frame = ctl.wb.valid ? idx_r[FRAME_W-1:0] : '0;
        idx_nxt      = last ? '0 : idx_r + 1'b1;
        if (last) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end
      end

      // lookup and ranked victim search in one pass
      S_LOOK: begin
        ctl.shift = 1'b1;
        idx_nxt   = last ? '0 : idx_r + 1'b1;
        if (idx_r == page_r) begin
          hit_nxt  = head.valid;
          hfrm_nxt = head.frame;
        end
        if ((idx_r != '0) && head.valid && !done_r) begin
          found_nxt  = 1'b1;
          victim_nxt = idx_r;
          vframe_nxt = head.frame;
          if (seen_r == target_r) begin
            done_nxt = 1'b1;
          end else begin
            seen_nxt = seen_r + 1'b1;
          end
        end
        if (last) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_nxt = '0;
        if (hit_r) begin
          res_nxt.hit   = 1'b1;
          res_nxt.frame = hfrm_r;
          state_nxt     = S_DONE;
        end else if (!found_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MOVE;
        end
      end

      // hand the victim's frame to the requested page
      S_MOVE: begin
        ctl.shift = 1'b1;
        idx_nxt   = last ? '0 : idx_r + 1'b1;
        if (idx_r == page_r) begin
          ctl.wb.valid = 1'b1;
          ctl.wb.frame = vframe_r;
        end else if (idx_r == victim_r) begin
          ctl.wb.valid = 1'b0;
          ctl.wb.frame = '0;
        end
        if (last) begin
          res_nxt.hit           = 1'b0;
          res_nxt.frame         = vframe_r;
          res_nxt.load_needed   = 1'b1;
          res_nxt.evicted_page  = victim_r;
          res_nxt.evicted_valid = 1'b1;
          res_nxt.bad_page      = 1'b0;
          state_nxt             = S_DONE;
        end
      end

      // wait for a free output slot
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      seen_r      <= '0;
      hit_r       <= 1'b0;
      found_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      seen_r      <= seen_nxt;
      hit_r       <= hit_nxt;
      found_r     <= found_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    target_r   <= target_nxt;
    init_cnt_r <= init_cnt_nxt;
    hfrm_r     <= hfrm_nxt;
    victim_r   <= victim_nxt;
    vframe_r   <= vframe_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = out_res_r;

  // ring is back in alignment whenever no pass is running
  `RPT_ASSERT_IMPL(a_idle_aligned, clk, rst_n, (state_r == S_IDLE) || (state_r == S_DONE),
                   (idx_r == '0), "ring left misaligned after a pass")
  // page 0 is never picked as victim
  `RPT_ASSERT_IMPL(a_victim_nonzero, clk, rst_n, found_r, (victim_r != '0),
                   "page 0 chosen as victim")
  // eviction pass only after a miss that found a victim
  `RPT_ASSERT_IMPL(a_move_cause, clk, rst_n, (state_r == S_MOVE), (found_r && !hit_r),
                   "eviction pass without a victim")
  // rank counter never passes the clamped rank
  `RPT_ASSERT_IMPL(a_seen_bound, clk, rst_n, (state_r == S_LOOK), (seen_r <= target_r),
                   "victim rank counter overran")
  // a finished item always lands in the output register
  `RPT_ASSERT_NEXT(a_done_loads, clk, rst_n, (state_r == S_DONE) && (state_nxt == S_IDLE),
                   out_valid_r, "result lost on completion")

endmodule

// ----- rtl/core/random_page_replacement_table_top.sv -----
// ----------------------------------------------------------------------------
// Random page replacement table - top level
// Page table mapping image pages onto buffer frames with random eviction.
// ----------------------------------------------------------------------------
// The table is a ring of 256 cells, one per page, that rotates one place per
// clock during each pass over it; every lookup, victim search, eviction and
// init is one full turn of that ring. One item is worked on at a time, and a
// new item is taken while the previous result still waits at the output.
// An out-of-range page goes straight to the result; an init is one turn, a
// hit or a miss with nothing to evict one turn and a decision step, and an
// evicting miss two turns (search, then move). Reset clears every entry at
// once; no clearing pass is needed. Configuration is written through the APB
// port (num_pages 0x0, resident_count 0x4) while idle; the user must ensure this.
// ----------------------------------------------------------------------------
module random_page_replacement_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // item input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [rpt_pkg::PAGE_W-1:0]    in_page,
  input  logic [rpt_pkg::RANK_W-1:0]    in_victim_rank,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [rpt_pkg::FRAME_W-1:0]   out_frame,
  output logic                          out_load_needed,
  output logic [rpt_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic                          out_evicted_valid,
  output logic                          out_bad_page,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpt_pkg::CFG_AW-1:0]    paddr,
  input  logic [rpt_pkg::CFG_DW-1:0]    pwdata,
  output logic [rpt_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import rpt_pkg::*;

  logic [NPAGES_W-1:0] num_pages_r;
  logic [RCOUNT_W-1:0] resident_count_r;
  logic                cfg_wr;
  logic                cfg_idx;
  entry_t              head;
  chain_ctl_t          ctl;
  result_t             res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pages_r      <= NPAGES_RST;
      resident_count_r <= RCOUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NUM_PAGES:      num_pages_r      <= pwdata[NPAGES_W-1:0];
        REG_RESIDENT_COUNT: resident_count_r <= pwdata[RCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_NUM_PAGES:      prdata = CFG_DW'(num_pages_r);
      REG_RESIDENT_COUNT: prdata = CFG_DW'(resident_count_r);
      default:            prdata = '0;
    endcase
  end

  // item sequencer
  rpt_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_page        (in_page),
    .in_victim_rank (in_victim_rank),
    .num_pages      (num_pages_r),
    .resident_count (resident_count_r),
    .head           (head),
    .ctl            (ctl),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res            (res)
  );

  // page table ring
  rpt_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .head  (head)
  );

  // result fields
  assign out_hit           = res.hit;
  assign out_frame         = res.frame;
  assign out_load_needed   = res.load_needed;
  assign out_evicted_page  = res.evicted_page;
  assign out_evicted_valid = res.evicted_valid;
  assign out_bad_page      = res.bad_page;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random page replacement table - regression testbench
// Sends page accesses and table initialisations through the item channel.
// A local copy of the page table predicts every result item, and each result
// is compared field by field with the oldest prediction. Both registers are
// rewritten between phases, with the extreme settings among them.
// ----------------------------------------------------------------------------
module testbench;
  import rpt_pkg::*;

  localparam int SEGMENTS     = 12;
  localparam int SEGMENT_REQS = 130;
  localparam int QUIET_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 600;

  // one request as the sender sees it
  typedef struct packed {
    logic              op;
    logic [PAGE_W-1:0] page;
    logic [RANK_W-1:0] rank;
  } page_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = OP_ACCESS;
  logic [PAGE_W-1:0]   in_page = '0;
  logic [RANK_W-1:0]   in_victim_rank = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic [FRAME_W-1:0]  out_frame;
  logic                out_load_needed;
  logic [PAGE_W-1:0]   out_evicted_page;
  logic                out_evicted_valid;
  logic                out_bad_page;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  random_page_replacement_table_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_page           (in_page),
    .in_victim_rank    (in_victim_rank),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_frame         (out_frame),
    .out_load_needed   (out_load_needed),
    .out_evicted_page  (out_evicted_page),
    .out_evicted_valid (out_evicted_valid),
    .out_bad_page      (out_bad_page),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // local copy of the page table and its settings
  logic               resident [PAGES];
  logic [FRAME_W-1:0] frame_of [PAGES];
  logic [NPAGES_W-1:0]  cfg_num_pages = NPAGES_RST;
  logic [RCOUNT_W-1:0]  cfg_resident_count = RCOUNT_RST;

  page_req_t lookup_q[$];
  result_t   outcome_q[$];
  page_req_t next_req;
  result_t   want;

  int send_idle_pct = 10;
  int recv_idle_pct = 10;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int n_items = 0, n_init = 0, n_hit = 0, n_evict = 0, n_no_victim = 0, n_bad = 0;

  // works out the result of one request and updates the local table
  function automatic result_t predict_lookup(input page_req_t req);
    result_t     res;
    int unsigned span, limit, target, seen;
    int          p, victim;
    res = '0;
    n_items++;
    if (req.op == OP_INIT) begin
      span = cfg_resident_count;
      if (cfg_num_pages < span) span = cfg_num_pages;
      if (FRAMES < span) span = FRAMES;
      if (PAGES < span) span = PAGES;
      for (p = 0; p < PAGES; p++) begin
        resident[p] = (p < span);
        frame_of[p] = (p < span) ? FRAME_W'(p) : '0;
      end
      n_init++;
      return res;
    end
    limit = (cfg_num_pages < PAGES) ? cfg_num_pages : PAGES;
    if (req.page >= limit) begin
      res.bad_page = 1'b1;
      n_bad++;
      return res;
    end
    if (resident[req.page]) begin
      res.hit   = 1'b1;
      res.frame = frame_of[req.page];
      n_hit++;
      return res;
    end
    // victim walk over pages 1 and up, page 0 is pinned
    target = 0;
    if (cfg_resident_count >= 2)
      target = (req.rank < cfg_resident_count - 2) ? req.rank : cfg_resident_count - 2;
    victim = -1;
    seen = 0;
    for (p = 1; p < PAGES; p++) begin
      if (resident[p]) begin
        victim = p;
        if (seen == target) break;
        seen++;
      end
    end
    if (victim < 0) begin
      n_no_victim++;
      return res;
    end
    frame_of[req.page] = frame_of[victim];
    resident[req.page] = 1'b1;
    resident[victim]   = 1'b0;
    frame_of[victim]   = '0;
    res.frame         = frame_of[req.page];
    res.load_needed   = 1'b1;
    res.evicted_page  = PAGE_W'(victim);
    res.evicted_valid = 1'b1;
    n_evict++;
    return res;
  endfunction

  // draws one request, mostly in range, some on low pages to raise the hit rate
  function automatic page_req_t random_req();
    page_req_t   r;
    int unsigned pick;
    pick   = $urandom_range(0, 99);
    r.op   = (pick < 3) ? OP_INIT : OP_ACCESS;
    r.rank = RANK_W'($urandom());
    if (pick < 70)
      r.page = PAGE_W'($urandom_range(0, int'(cfg_num_pages) - 1));
    else if (pick < 85)
      r.page = PAGE_W'($urandom_range(0, int'(cfg_resident_count) + 8));
    else
      r.page = PAGE_W'($urandom());
    return r;
  endfunction

  function automatic void queue_req(input logic op, input int unsigned page,
                                    input int unsigned rank);
    lookup_q.push_back({op, PAGE_W'(page), RANK_W'(rank)});
  endfunction

  // waits until every request has gone in and every result has come out
  task automatic wait_drained();
    do @(negedge clk);
    while (lookup_q.size() != 0 || in_valid || outcome_q.size() != 0);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_reg(input logic idx, input int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_NUM_PAGES) cfg_num_pages = NPAGES_W'(value);
    else cfg_resident_count = RCOUNT_W'(value);
    @(negedge clk);
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (lookup_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = lookup_q.pop_front();
        in_valid       <= 1'b1;
        in_op          <= next_req.op;
        in_page        <= next_req.page;
        in_victim_rank <= next_req.rank;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor, predictor hook and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result item with nothing outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            mismatches++;
          end
          if (out_frame !== want.frame) begin
            $error("frame: expected %0d, got %0d", want.frame, out_frame);
            mismatches++;
          end
          if (out_load_needed !== want.load_needed) begin
            $error("load_needed: expected %0d, got %0d", want.load_needed, out_load_needed);
            mismatches++;
          end
          if (out_evicted_page !== want.evicted_page) begin
            $error("evicted_page: expected %0d, got %0d", want.evicted_page,
                   out_evicted_page);
            mismatches++;
          end
          if (out_evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
                   out_evicted_valid);
            mismatches++;
          end
          if (out_bad_page !== want.bad_page) begin
            $error("bad_page: expected %0d, got %0d", want.bad_page, out_bad_page);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        outcome_q.push_back(predict_lookup({in_op, in_page, in_victim_rank}));
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no item moved for %0d cycles", QUIET_LIMIT);
        $display("random_page_replacement_table_top regression: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned np, rc;
    int          seg, i;
    for (i = 0; i < PAGES; i++) begin
      resident[i] = 1'b0;
      frame_of[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table after reset, then init and the eviction corner cases
    queue_req(OP_ACCESS, 0, 0);
    queue_req(OP_ACCESS, 255, 63);
    queue_req(OP_INIT, 255, 63);
    queue_req(OP_ACCESS, 0, 0);
    queue_req(OP_ACCESS, 63, 0);
    queue_req(OP_ACCESS, 64, 0);
    queue_req(OP_ACCESS, 255, 63);
    queue_req(OP_ACCESS, 128, 62);
    queue_req(OP_ACCESS, 64, 0);
    wait_drained();

    // smallest settings: every page but page 0 out of range
    write_reg(REG_NUM_PAGES, 1);
    write_reg(REG_RESIDENT_COUNT, 2);
    queue_req(OP_ACCESS, 1, 0);
    queue_req(OP_ACCESS, 255, 63);
    queue_req(OP_INIT, 0, 0);
    queue_req(OP_ACCESS, 0, 0);
    wait_drained();

    // only page 0 resident: a miss finds nothing to evict; an init then makes pages 0 and 1 resident
    write_reg(REG_NUM_PAGES, 256);
    queue_req(OP_ACCESS, 170, 21);
    queue_req(OP_INIT, 0, 0);
    queue_req(OP_ACCESS, 85, 42);
    queue_req(OP_ACCESS, 200, 5);
    wait_drained();

    // rank beyond the resident pages takes the last one found
    write_reg(REG_RESIDENT_COUNT, 64);
    queue_req(OP_ACCESS, 7, 40);
    wait_drained();

    write_reg(REG_NUM_PAGES, 100);
    queue_req(OP_INIT, 0, 0);
    queue_req(OP_ACCESS, 99, 17);
    queue_req(OP_ACCESS, 100, 0);

    // random phases, each with its own settings, drained in between
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      if (seg == 0) begin
        np = 256;
        rc = 64;
      end else begin
        case ($urandom_range(0, 5))
          0:       np = 1;
          1, 2:    np = 256;
          default: np = $urandom_range(2, 255);
        endcase
        case ($urandom_range(0, 4))
          0:       rc = 2;
          1:       rc = 64;
          default: rc = $urandom_range(2, 64);
        endcase
      end
      write_reg(REG_NUM_PAGES, np);
      write_reg(REG_RESIDENT_COUNT, rc);
      // one phase runs with no idling on either side
      send_idle_pct = (seg == 4) ? 0 : 10;
      recv_idle_pct = (seg == 4) ? 0 : 10;
      if (seg == 0 || $urandom_range(0, 3) != 0)
        queue_req(OP_INIT, $urandom(), $urandom());
      for (i = 0; i < SEGMENT_REQS; i++)
        lookup_q.push_back(random_req());
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d items: %0d inits, %0d hits, %0d evictions", n_items, n_init,
             n_hit, n_evict);
    $display("%0d misses with no victim, %0d out-of-range pages, %0d mismatches",
             n_no_victim, n_bad, mismatches);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("random_page_replacement_table_top regression: pass");
    end else begin
      $display("random_page_replacement_table_top regression: fail");
    end
    $finish;
  end

endmodule
